FILE: rtl/kdlpr_pkg.sv
package kdlpr_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;
    localparam int MsCountW = 23;
    localparam int UnitW    = 8;
    localparam int ShiftW   = 4;
    localparam int StateW   = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PRESS_LEVEL  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_EVENT_MODE   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT       = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_LONG_SHIFT   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT_SHIFT = 3'd6;

    // key states
    localparam logic [StateW-1:0] ST_RELEASED   = 3'd0;
    localparam logic [StateW-1:0] ST_PRESS_DB   = 3'd1;
    localparam logic [StateW-1:0] ST_PRESSED    = 3'd2;
    localparam logic [StateW-1:0] ST_LONG       = 3'd3;
    localparam logic [StateW-1:0] ST_PRESS_RLS  = 3'd4;
    localparam logic [StateW-1:0] ST_LONG_RLS   = 3'd5;

    typedef struct packed {
        logic              press_level;
        logic              event_mode;
        logic [UnitW-1:0]  debounce_delay;
        logic [UnitW-1:0]  long_press_delay;
        logic [UnitW-1:0]  repeat_delay;
        logic [ShiftW-1:0] long_shift;
        logic [ShiftW-1:0] repeat_shift;
    } t_cfg;

    typedef struct packed {
        logic check;
        logic clear;
    } t_tmr_cmd;

    typedef struct packed {
        logic [StateW-1:0] key_state_code;
        logic              event_pending;
        logic              report_released;
        logic              report_pressed;
        logic              report_long;
    } t_res;

endpackage

FILE: rtl/kdlpr_in_if.sv
interface kdlpr_in_if;
    logic valid;
    logic ready;
    logic key_level;
    logic event_ack;

    modport source (output valid, output key_level, output event_ack, input ready);
    modport sink (input valid, input key_level, input event_ack, output ready);
endinterface

FILE: rtl/kdlpr_out_if.sv
interface kdlpr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_state_code;
    logic       event_pending;
    logic       report_released;
    logic       report_pressed;
    logic       report_long;

    modport source (
        output valid, output key_state_code, output event_pending,
        output report_released, output report_pressed, output report_long,
        input ready
    );
    modport sink (
        input valid, input key_state_code, input event_pending,
        input report_released, input report_pressed, input report_long,
        output ready
    );
endinterface

FILE: rtl/kdlpr_cfg.sv
module kdlpr_cfg
    import kdlpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_level      <= 1'b0;
            r_cfg.event_mode       <= 1'b0;
            r_cfg.debounce_delay   <= 8'd20;
            r_cfg.long_press_delay <= 8'd16;
            r_cfg.repeat_delay     <= 8'd4;
            r_cfg.long_shift       <= 4'd6;
            r_cfg.repeat_shift     <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESS_LEVEL:  r_cfg.press_level      <= i_cfg_data[0];
                CFG_EVENT_MODE:   r_cfg.event_mode       <= i_cfg_data[0];
                CFG_DEBOUNCE:     r_cfg.debounce_delay   <= i_cfg_data[UnitW-1:0];
                CFG_LONG_PRESS:   r_cfg.long_press_delay <= i_cfg_data[UnitW-1:0];
                CFG_REPEAT:       r_cfg.repeat_delay     <= i_cfg_data[UnitW-1:0];
                CFG_LONG_SHIFT:   r_cfg.long_shift       <= i_cfg_data[ShiftW-1:0];
                CFG_REPEAT_SHIFT: r_cfg.repeat_shift     <= i_cfg_data[ShiftW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/kdlpr_timer.sv
module kdlpr_timer
    import kdlpr_pkg::*;
#(
    parameter bit Restart = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_tmr_cmd         i_cmd,
    input  logic [UnitW-1:0] i_unit,
    input  logic [UnitW-1:0] i_delay,
    output logic             o_fire
);

    logic             r_valid;
    logic [UnitW-1:0] r_start;
    logic [UnitW-1:0] elapsed;

    assign elapsed = i_unit - r_start;
    // a clear in the same step makes the check see an idle timer
    assign o_fire  = r_valid && (elapsed > i_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            if (i_cmd.check) begin
                if (!r_valid || i_cmd.clear) begin
                    r_valid <= 1'b1;
                end else if (o_fire && !Restart) begin
                    r_valid <= 1'b0;
                end
            end else if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_cmd.check) begin
            if (!r_valid || i_cmd.clear || (o_fire && Restart)) begin
                r_start <= i_unit;
            end
        end
    end

endmodule

FILE: rtl/kdlpr_core.sv
module kdlpr_core
    import kdlpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_step,
    input  logic i_key_level,
    input  logic i_event_ack,
    output t_res o_res
);

    logic [StateW-1:0]   r_state, n_state;
    logic                r_event;
    logic [MsCountW-1:0] r_ms_count;
    logic                down, ev_set, ev_now, gate;
    t_tmr_cmd            db_cmd, lp_cmd, rp_cmd;
    logic                db_fire, lp_fire, rp_fire;
    logic [UnitW-1:0]    db_unit, lp_unit, rp_unit;

    function automatic logic [UnitW-1:0] unit_of(logic [MsCountW-1:0] cnt,
                                                 logic [ShiftW-1:0] sh);
        logic [MsCountW-1:0] shifted;
        shifted = cnt >> sh;
        return shifted[UnitW-1:0];
    endfunction

    assign down    = (i_key_level == i_cfg.press_level);
    assign db_unit = r_ms_count[UnitW-1:0];
    assign lp_unit = unit_of(r_ms_count, i_cfg.long_shift);
    assign rp_unit = unit_of(r_ms_count, i_cfg.repeat_shift);

    kdlpr_timer #(.Restart(1'b0)) u_db_timer (
        .i_clk, .i_rst_n, .i_en(i_step), .i_cmd(db_cmd), .i_unit(db_unit),
        .i_delay(i_cfg.debounce_delay), .o_fire(db_fire)
    );

    kdlpr_timer #(.Restart(1'b0)) u_lp_timer (
        .i_clk, .i_rst_n, .i_en(i_step), .i_cmd(lp_cmd), .i_unit(lp_unit),
        .i_delay(i_cfg.long_press_delay), .o_fire(lp_fire)
    );

    kdlpr_timer #(.Restart(1'b1)) u_rp_timer (
        .i_clk, .i_rst_n, .i_en(i_step), .i_cmd(rp_cmd), .i_unit(rp_unit),
        .i_delay(i_cfg.repeat_delay), .o_fire(rp_fire)
    );

    always_comb begin
        n_state = r_state;
        ev_set  = 1'b0;
        db_cmd  = '0;
        lp_cmd  = '0;
        rp_cmd  = '0;
        case (r_state)
            ST_PRESS_DB: begin
                if (!down) begin
                    n_state      = ST_RELEASED;
                    db_cmd.clear = 1'b1;
                end else begin
                    db_cmd.check = 1'b1;
                    if (db_fire) begin
                        n_state = ST_PRESSED;
                        ev_set  = 1'b1;
                    end
                end
            end
            ST_PRESSED: begin
                if (!down) begin
                    n_state      = ST_PRESS_RLS;
                    lp_cmd.clear = 1'b1;
                end else begin
                    lp_cmd.check = 1'b1;
                    if (lp_fire) begin
                        n_state = ST_LONG;
                        ev_set  = 1'b1;
                    end
                end
            end
            ST_LONG: begin
                // the repeat check runs even on release, against a cleared timer
                rp_cmd.check = 1'b1;
                if (!down) begin
                    n_state      = ST_LONG_RLS;
                    rp_cmd.clear = 1'b1;
                end else if (rp_fire) begin
                    ev_set = 1'b1;
                end
            end
            ST_PRESS_RLS, ST_LONG_RLS: begin
                if (down) begin
                    n_state      = (r_state == ST_PRESS_RLS) ? ST_PRESSED : ST_LONG;
                    db_cmd.clear = 1'b1;
                end else begin
                    db_cmd.check = 1'b1;
                    if (db_fire) begin
                        n_state      = ST_RELEASED;
                        ev_set       = 1'b1;
                        rp_cmd.clear = 1'b1;
                    end
                end
            end
            default: begin
                n_state = down ? ST_PRESS_DB : ST_RELEASED;
            end
        endcase
    end

    assign ev_now = r_event | ev_set;
    assign gate   = i_cfg.event_mode ? ev_now : 1'b1;

    always_comb begin
        o_res.key_state_code  = n_state;
        o_res.event_pending   = ev_now;
        o_res.report_released = gate && (n_state == ST_RELEASED);
        o_res.report_pressed  = gate && (n_state == ST_PRESSED || n_state == ST_PRESS_RLS);
        o_res.report_long     = gate && (n_state == ST_LONG || n_state == ST_LONG_RLS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RELEASED;
            r_event    <= 1'b0;
            r_ms_count <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_event    <= ev_now && !i_event_ack;
            r_ms_count <= r_ms_count + 1'b1;
        end
    end

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_state) && $stable(r_event) && $stable(r_ms_count))
        else $error("key state changed without a tick");

    a_count_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_ms_count == $past(r_ms_count) + 1'b1)
        else $error("millisecond count did not advance");

    a_from_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_state == ST_RELEASED |=> r_state == ST_RELEASED || r_state == ST_PRESS_DB)
        else $error("released key skipped press debounce");

endmodule

FILE: rtl/key_debounce_long_press_repeat.sv
// Key debounce with long press and auto-repeat. Every request on i_in is one
// millisecond tick carrying the sampled key level and an event acknowledge;
// every tick yields exactly one result on o_out with the key state code, the
// pending event flag and the released / pressed / long reports. A tick is
// taken every clock while o_out does not stall: it lands in an input register,
// passes the state machine and its three wrap-around timers, and the result
// sits in an output register, so a new tick is taken while the previous result
// still waits. Each tick passes the input and then the output register.
// Write the configuration registers only while no tick is in flight.
module key_debounce_long_press_repeat
    import kdlpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    kdlpr_in_if.sink            i_in,
    kdlpr_out_if.source         o_out
);

    t_cfg cfg;
    t_res res;
    logic r_s1_valid;
    logic r_s1_key;
    logic r_s1_ack;
    logic r_out_valid;
    t_res r_out;
    logic s1_adv;

    kdlpr_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_cfg(cfg)
    );

    // advance the input stage whenever the output register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_key <= i_in.key_level;
            r_s1_ack <= i_in.event_ack;
        end
    end

    kdlpr_core u_core (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_step(s1_adv),
        .i_key_level(r_s1_key), .i_event_ack(r_s1_ack), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.key_state_code  = r_out.key_state_code;
    assign o_out.event_pending   = r_out.event_pending;
    assign o_out.report_released = r_out.report_released;
    assign o_out.report_pressed  = r_out.report_pressed;
    assign o_out.report_long     = r_out.report_long;

endmodule
